// ----- design/sum_pkg.sv -----
`default_nettype none
package sum_pkg;

   localparam int ElemWidth  = 32;
   localparam int CountWidth = 6;

   typedef logic signed [ElemWidth-1:0] elem_type;
   typedef logic [CountWidth-1:0]       count_type;

   // Command broadcast from the top level to every cell of the chain
   typedef struct packed {
      logic insert;   // place the new value, shift larger ones right
      logic shift;    // move every entry one cell toward cell 0
      logic clear;    // drop all entries
   } cell_cmd_type;

endpackage
`default_nettype wire

// ----- design/sum_cell.sv -----
`default_nettype none
module sum_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  sum_pkg::cell_cmd_type  cmd,
   input  sum_pkg::elem_type      new_value,
   input  wire                    left_take,
   input  sum_pkg::elem_type      left_value,
   input  wire                    left_valid,
   input  sum_pkg::elem_type      right_value,
   input  wire                    right_valid,
   output logic                   take,
   output logic                   equal,
   output sum_pkg::elem_type      value,
   output logic                   valid
);
   import sum_pkg::*;

   elem_type value_ff, value_in;
   logic     valid_ff, valid_in;
   logic     greater;

   // take marks the insertion point and every cell to the right of it
   assign greater = valid_ff && (value_ff > new_value);
   assign equal   = valid_ff && (value_ff == new_value);
   assign take    = greater || !valid_ff;
   assign value   = value_ff;
   assign valid   = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      priority if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (cmd.insert && take) begin
         value_in = left_take ? left_value : new_value;
         valid_in = valid_ff || left_valid;
      end else begin
         // hold the entry
         value_in = value_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

// ----- design/sort_unique_merge.sv -----
`default_nettype none
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  has_value, element, end_of_set
// rsp_      out        rsp_valid / rsp_stall  out_valid_value, out_element, run_last,
//                                             distinct_count, overflowed
//
// An input transfer places its value in the cell chain in the cycle it is accepted.
// An end-of-set transfer starts a drain that shows one result per distinct value
// (or one empty result), one per cycle while rsp_stall is low. req_stall stays
// high during the drain. reset is synchronous and empties the chain at once. A
// stalled result holds, since it is read straight from cell 0 and the drain
// counters.
module sort_unique_merge #(
   parameter int CAPACITY = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_has_value,
   input  sum_pkg::elem_type   req_element,
   input  wire                 req_end_of_set,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic                rsp_out_valid_value,
   output sum_pkg::elem_type   rsp_out_element,
   output logic                rsp_run_last,
   output sum_pkg::count_type  rsp_distinct_count,
   output logic                rsp_overflowed
);
   import sum_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   // Chain links: index i + 1 carries the outputs of cell i, so index i is the
   // left side of cell i and index i + 2 its right side; the last index is past
   // the end of the chain
   logic     link_take  [CAPACITY+1];
   elem_type link_value [CAPACITY+2];
   logic     link_valid [CAPACITY+2];
   logic     cell_equal [CAPACITY];

   cell_cmd_type cmd;

   logic          drain_ff, drain_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          ovf_ff, ovf_in;

   logic          req_xfer, rsp_xfer, finish;
   logic          dup, full, do_insert;
   logic [CW+CountWidth-1:0] count_ext;

   // Left end of the chain: nothing shifts in, and cell 0 may fill when empty
   assign link_take[0]  = 1'b0;
   assign link_value[0] = '0;
   assign link_valid[0] = 1'b1;
   // Right end: an empty slot shifts in on drain
   assign link_value[CAPACITY+1] = '0;
   assign link_valid[CAPACITY+1] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sum_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_value   (req_element),
         .left_take   (link_take[i]),
         .left_value  (link_value[i]),
         .left_valid  (link_valid[i]),
         .right_value (link_value[i+2]),
         .right_valid (link_valid[i+2]),
         .take        (link_take[i+1]),
         .equal       (cell_equal[i]),
         .value       (link_value[i+1]),
         .valid       (link_valid[i+1])
      );
   end

   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         dup = dup | cell_equal[i];
      end
   end

   assign req_stall = drain_ff;
   assign req_xfer  = req_valid && !drain_ff;
   assign rsp_xfer  = drain_ff && !rsp_stall;
   assign full      = (count_ff == CW'(CAPACITY));
   assign do_insert = req_xfer && req_has_value && !dup && !full;
   // Last result of the set goes out (an empty set has one result too)
   assign finish    = rsp_xfer && (remain_ff <= CW'(1));

   always_comb begin
      cmd.insert = do_insert;
      cmd.shift  = rsp_xfer && !finish;
      cmd.clear  = finish;
   end

   always_comb begin
      drain_in  = drain_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      ovf_in    = ovf_ff;
      priority if (finish) begin
         drain_in = 1'b0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (rsp_xfer) begin
         remain_in = remain_ff - CW'(1);
      end else if (req_xfer) begin
         count_in = count_ff + CW'(do_insert);
         if (req_has_value && !dup && full) begin
            ovf_in = 1'b1;
         end
         if (req_end_of_set) begin
            drain_in  = 1'b1;
            remain_in = count_in;
         end
      end else begin
         // hold while idle or stalled
         drain_in  = drain_ff;
         remain_in = remain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff  <= 1'b0;
         count_ff  <= '0;
         remain_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         drain_ff  <= drain_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         ovf_ff    <= ovf_in;
      end
   end

   // Results come straight from cell 0 and the held counters
   assign count_ext           = {{CountWidth{1'b0}}, count_ff};
   assign rsp_valid           = drain_ff;
   assign rsp_out_valid_value = (remain_ff != '0);
   assign rsp_out_element     = (remain_ff != '0) ? link_value[1] : '0;
   assign rsp_run_last        = (remain_ff <= CW'(1));
   assign rsp_distinct_count  = count_ext[CountWidth-1:0];
   assign rsp_overflowed      = ovf_ff;

endmodule
`default_nettype wire

// ----- design/sum_checker.sv -----
`default_nettype none
module sum_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_stall,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input wire                 rsp_out_valid_value,
   input sum_pkg::elem_type   rsp_out_element,
   input wire                 rsp_run_last,
   input sum_pkg::count_type  rsp_distinct_count
);
   import sum_pkg::*;

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_element)
         && $stable(rsp_run_last))
      else $error("stalled result changed");

   // No new input while a set drains
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during drain");

   // Empty set result is alone and carries a zero count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid_value |-> rsp_run_last && (rsp_distinct_count == '0))
      else $error("bad empty-set result");

   // Results of one set come in strictly ascending order without gaps
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=>
         rsp_valid && rsp_out_valid_value && (rsp_out_element > $past(rsp_out_element)))
      else $error("results not strictly ascending");

endmodule

bind sort_unique_merge sum_checker u_sum_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_valid_value (rsp_out_valid_value),
   .rsp_out_element     (rsp_out_element),
   .rsp_run_last        (rsp_run_last),
   .rsp_distinct_count  (rsp_distinct_count)
);
`default_nettype wire

// ----- bench/sort_unique_merge_check.sv -----
`timescale 1ns / 100ps
module sort_unique_merge_check #(
   parameter int CAPACITY = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_stall,
   input  wire                 req_has_value,
   input  sum_pkg::elem_type   req_element,
   input  wire                 req_end_of_set,
   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  wire                 rsp_out_valid_value,
   input  sum_pkg::elem_type   rsp_out_element,
   input  wire                 rsp_run_last,
   input  sum_pkg::count_type  rsp_distinct_count,
   input  wire                 rsp_overflowed,
   output int                  mismatch_total,
   output int                  results_pending,
   output int                  results_checked,
   output int                  overflow_sets
);
   import sum_pkg::*;

   typedef struct {
      logic      has_value;
      elem_type  element;
      logic      last;
      count_type count;
      logic      overflowed;
   } drain_entry_type;

   elem_type        held_values [CAPACITY];
   int              held_total;
   logic            overflow_seen;
   drain_entry_type drain_due [$];
   drain_entry_type due;
   int              errors;
   int              checked;
   int              overflowed_sets;

   initial begin
      held_total      = 0;
      overflow_seen   = 1'b0;
      errors          = 0;
      checked         = 0;
      overflowed_sets = 0;
      mismatch_total  = 0;
      results_pending = 0;
      results_checked = 0;
      overflow_sets   = 0;
   end

   // Merge one value into the ascending list of distinct values.
   function automatic void absorb_value(input elem_type value);
      int pos;
      int i;
      pos = 0;
      while (pos < held_total && held_values[pos] < value)
         pos++;
      if (pos < held_total && held_values[pos] == value)
         return;
      if (held_total >= CAPACITY) begin
         overflow_seen = 1'b1;
         return;
      end
      for (i = held_total; i > pos; i--)
         held_values[i] = held_values[i - 1];
      held_values[pos] = value;
      held_total++;
   endfunction

   // Queue the drain of the current set, then empty the list.
   function automatic void release_set();
      drain_entry_type entry;
      int i;
      entry.has_value  = 1'b0;
      entry.element    = '0;
      entry.last       = 1'b1;
      entry.count      = '0;
      entry.overflowed = overflow_seen;
      if (held_total == 0)
         drain_due.push_back(entry);
      for (i = 0; i < held_total; i++) begin
         entry.has_value = 1'b1;
         entry.element   = held_values[i];
         entry.last      = (i == held_total - 1);
         entry.count     = count_type'(held_total);
         drain_due.push_back(entry);
      end
      if (overflow_seen)
         overflowed_sets++;
      held_total    = 0;
      overflow_seen = 1'b0;
   endfunction

   task automatic compare_field(input string field, input logic signed [33:0] want,
                                input logic signed [33:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_total    = 0;
         overflow_seen = 1'b0;
         drain_due.delete();
      end else begin
         // Input side first, so a drain seen at the same edge finds its entries.
         if (req_valid && !req_stall) begin
            if (req_has_value)
               absorb_value(req_element);
            if (req_end_of_set)
               release_set();
         end
         if (rsp_valid && !rsp_stall) begin
            if (drain_due.size() == 0) begin
               $error("unexpected result transfer: element %0d, run_last %0b",
                      rsp_out_element, rsp_run_last);
               errors++;
            end else begin
               due = drain_due.pop_front();
               compare_field("out_valid_value", due.has_value, rsp_out_valid_value);
               compare_field("out_element", due.element, rsp_out_element);
               compare_field("run_last", due.last, rsp_run_last);
               compare_field("distinct_count", due.count, rsp_distinct_count);
               compare_field("overflowed", due.overflowed, rsp_overflowed);
               checked++;
            end
         end
      end
      mismatch_total  <= errors;
      results_pending <= drain_due.size();
      results_checked <= checked;
      overflow_sets   <= overflowed_sets;
   end

endmodule

// ----- bench/sort_unique_merge_tb.sv -----
`timescale 1ns / 100ps
module sort_unique_merge_tb;
   import sum_pkg::*;

   localparam int CAPACITY       = 32;
   localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before the run is called hung
   localparam int TAIL_CYCLES    = 40;    // extra cycles to catch stray results
   localparam int PHASE_ITEMS    = 70;    // value-bearing transfers per idling phase

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_has_value = 1'b0;
   elem_type  req_element = '0;
   logic      req_end_of_set = 1'b0;
   logic      rsp_stall = 1'b0;
   wire       req_stall;
   wire       rsp_valid;
   wire       rsp_out_valid_value;
   elem_type  rsp_out_element;
   wire       rsp_run_last;
   count_type rsp_distinct_count;
   wire       rsp_overflowed;

   int mismatch_total;
   int results_pending;
   int results_checked;
   int overflow_sets;

   int idle_pct = 0;     // chance per cycle that the sender holds off
   int stall_pct = 0;    // chance per cycle that the receiver stalls
   int counted_items = 0;
   int sets_sent = 0;
   int quiet_cycles = 0;
   int phase;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sort_unique_merge #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_has_value(req_has_value),
      .req_element(req_element),
      .req_end_of_set(req_end_of_set),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_valid_value(rsp_out_valid_value),
      .rsp_out_element(rsp_out_element),
      .rsp_run_last(rsp_run_last),
      .rsp_distinct_count(rsp_distinct_count),
      .rsp_overflowed(rsp_overflowed)
   );

   sort_unique_merge_check #(
      .CAPACITY(CAPACITY)
   ) result_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_has_value(req_has_value),
      .req_element(req_element),
      .req_end_of_set(req_end_of_set),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_valid_value(rsp_out_valid_value),
      .rsp_out_element(rsp_out_element),
      .rsp_run_last(rsp_run_last),
      .rsp_distinct_count(rsp_distinct_count),
      .rsp_overflowed(rsp_overflowed),
      .mismatch_total(mismatch_total),
      .results_pending(results_pending),
      .results_checked(results_checked),
      .overflow_sets(overflow_sets)
   );

   // Receiver: stall at random with the current phase's odds; hold low in reset.
   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < stall_pct);
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one item and hold it until the block takes it. Idle cycles go in
   // front of the item, so valid drops only between transfers.
   task automatic send_item(input logic has_value, input elem_type value,
                            input logic end_of_set);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_has_value  <= has_value;
      req_element    <= value;
      req_end_of_set <= end_of_set;
      do @(posedge clock); while (req_stall);
      if (has_value)
         counted_items++;
      if (end_of_set)
         sets_sent++;
   endtask

   // Bias toward a narrow pool so duplicates are common, with extremes mixed in.
   // Wide picks mostly span the whole range, to fill the store past capacity.
   function automatic elem_type pick_value(input bit wide);
      if (wide && $urandom_range(3) != 0)
         return elem_type'($urandom);
      case ($urandom_range(9))
         0, 1, 2, 3: return elem_type'(int'($urandom_range(15)) - 8);
         4:          return elem_type'(32'h7fff_ffff - $urandom_range(3));
         5:          return elem_type'(32'h8000_0000 + $urandom_range(3));
         default:    return elem_type'($urandom);
      endcase
   endfunction

   // One well-formed set with random content, sprinkled with no-op items.
   task automatic random_set();
      int  size;
      int  i;
      bit  wide;
      bit  value_on_end;
      wide = 1'b0;
      case ($urandom_range(19))
         0:       size = 0;
         1, 2: begin
            size = $urandom_range(CAPACITY - 2, CAPACITY + 8);
            wide = 1'b1;
         end
         default: size = $urandom_range(1, 10);
      endcase
      value_on_end = (size > 0) && $urandom_range(1);
      for (i = 0; i < size; i++) begin
         if ($urandom_range(19) == 0)
            send_item(1'b0, elem_type'($urandom), 1'b0);
         if (value_on_end && i == size - 1)
            send_item(1'b1, pick_value(wide), 1'b1);
         else
            send_item(1'b1, pick_value(wide), 1'b0);
      end
      // A plain end marker carries random junk in the element field.
      if (!value_on_end)
         send_item(1'b0, elem_type'($urandom), 1'b1);
   endtask

   initial begin
      int i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling on either side.
      // A no-op item, then a set with no values at all.
      send_item(1'b0, elem_type'(32'h5a5a_5a5a), 1'b0);
      send_item(1'b0, elem_type'(32'ha5a5_a5a5), 1'b1);

      // Both extremes, zero and its neighbors, duplicates, last value on the end item.
      send_item(1'b1, elem_type'(32'h7fff_ffff), 1'b0);
      send_item(1'b1, elem_type'(32'h8000_0000), 1'b0);
      send_item(1'b1, elem_type'(0), 1'b0);
      send_item(1'b1, elem_type'(-1), 1'b0);
      send_item(1'b1, elem_type'(1), 1'b0);
      send_item(1'b1, elem_type'(32'h8000_0000), 1'b0);
      send_item(1'b1, elem_type'(32'h7fff_ffff), 1'b0);
      send_item(1'b1, elem_type'(0), 1'b1);

      // A set whose only value rides on the end item.
      send_item(1'b1, elem_type'(-5), 1'b1);

      // Repeats of one value collapse to a single result.
      send_item(1'b1, elem_type'(7), 1'b0);
      send_item(1'b1, elem_type'(7), 1'b0);
      send_item(1'b1, elem_type'(7), 1'b0);
      send_item(1'b0, elem_type'(0), 1'b1);

      // Fill the store in descending order, so every insert lands at the front.
      for (i = 0; i < CAPACITY; i++)
         send_item(1'b1, elem_type'(1000 - 7 * i), 1'b0);
      // Full store: a new value drops and flags, a held value merges quietly.
      send_item(1'b1, elem_type'(5000), 1'b0);
      send_item(1'b1, elem_type'(1000), 1'b0);
      send_item(1'b1, elem_type'(-1), 1'b1);

      // A full store without overflow, then an empty set that must not carry the flag.
      for (i = 0; i < CAPACITY; i++)
         send_item(1'b1, elem_type'(32'h8000_0000 + i), 1'b0);
      send_item(1'b0, elem_type'(0), 1'b1);
      send_item(1'b0, elem_type'(0), 1'b1);

      // Random part in four idling phases: none, sender, receiver, both.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 85; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 85; end
            default: begin idle_pct = 37; stall_pct <= 37; end
         endcase
         while (counted_items < 60 + (phase + 1) * PHASE_ITEMS)
            random_set();
      end
      req_valid <= 1'b0;

      // Drain: wait for every queued result, then a little longer for strays.
      do @(posedge clock); while (results_pending != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d value transfers in %0d sets, %0d results compared,",
               counted_items, sets_sent, results_checked);
      $display("%0d sets dropped values on a full store, four idling phases.",
               overflow_sets);
      if (mismatch_total == 0 && results_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
